// ===== hw/rtl/dxtd_pkg.sv =====
package dxtd_pkg;

   localparam int PIX_CNT_W = 4;
   localparam logic [PIX_CNT_W-1:0] LAST_PIX = 4'hF;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
   localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

   // block_format codes
   localparam logic FMT_DXT1 = 1'b0;
   localparam logic FMT_DXT3 = 1'b1;

   typedef struct packed {
      logic [63:0] color_block;
      logic [63:0] alpha_block;
   } dxtd_req_type;

   typedef struct packed {
      logic [31:0] pixel;
      logic [1:0]  column;
      logic [1:0]  row;
      logic        last;
   } dxtd_rsp_type;

   // one decoded block header waiting for the pixel sequencer
   typedef struct packed {
      logic             explicit_alpha;
      logic [31:0]      indices;
      logic [63:0]      alpha;
      logic [3:0][31:0] palette;
   } dxtd_entry_type;

endpackage

// ===== hw/rtl/dxtd_front.sv =====
module dxtd_front (
   input  logic                   req_valid,
   output logic                   req_ready,
   input  dxtd_pkg::dxtd_req_type req_data,
   input  logic                   block_format,
   output logic                   push_valid,
   input  logic                   push_ready,
   output dxtd_pkg::dxtd_entry_type push_entry
);
   import dxtd_pkg::*;

   localparam logic [10:0] DIV3_RECIP = 11'd683;
   localparam int          DIV3_SHIFT = 11;

   // exact for x < 2048, sums here stay below 768
   function automatic logic [7:0] div3(input logic [9:0] x);
      logic [20:0] p;
      p = 21'(x) * 21'(DIV3_RECIP);
      return p[DIV3_SHIFT +: 8];
   endfunction

   logic [15:0] c0, c1;
   logic [2:0][7:0] ch0, ch1, blend_a, blend_b, mid;
   logic four_color;
   logic [7:0] alpha;
   logic [9:0] sum_a, sum_b;
   logic [8:0] sum_m;

   assign c0 = req_data.color_block[15:0];
   assign c1 = req_data.color_block[31:16];
   assign four_color = c0 > c1;
   assign alpha = (block_format == FMT_DXT1) ? ALPHA_OPAQUE : ALPHA_CLEAR;

   // channel order: red, green, blue
   assign ch0[0] = {c0[15:11], 3'b000};
   assign ch0[1] = {c0[10:5], 2'b00};
   assign ch0[2] = {c0[4:0], 3'b000};
   assign ch1[0] = {c1[15:11], 3'b000};
   assign ch1[1] = {c1[10:5], 2'b00};
   assign ch1[2] = {c1[4:0], 3'b000};

   always_comb begin
      sum_a = '0;
      sum_b = '0;
      sum_m = '0;
      for (int k = 0; k < 3; k++) begin
         sum_a = {1'b0, ch0[k], 1'b0} + {2'b00, ch1[k]};
         sum_b = {2'b00, ch0[k]} + {1'b0, ch1[k], 1'b0};
         sum_m = {1'b0, ch0[k]} + {1'b0, ch1[k]};
         blend_a[k] = div3(sum_a);
         blend_b[k] = div3(sum_b);
         mid[k] = sum_m[8:1];
      end
   end

   always_comb begin
      push_entry.explicit_alpha = (block_format == FMT_DXT3);
      push_entry.indices = req_data.color_block[63:32];
      push_entry.alpha = req_data.alpha_block;
      push_entry.palette[0] = {alpha, ch0[0], ch0[1], ch0[2]};
      push_entry.palette[1] = {alpha, ch1[0], ch1[1], ch1[2]};
      if (four_color) begin
         push_entry.palette[2] = {alpha, blend_a[0], blend_a[1], blend_a[2]};
         push_entry.palette[3] = {alpha, blend_b[0], blend_b[1], blend_b[2]};
      end else begin
         // three-color mode, entry 3 is transparent black
         push_entry.palette[2] = {alpha, mid[0], mid[1], mid[2]};
         push_entry.palette[3] = '0;
      end
   end

   assign push_valid = req_valid;
   assign req_ready = push_ready;

endmodule

// ===== hw/rtl/dxtd_queue.sv =====
module dxtd_queue #(
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push_valid,
   output logic                     push_ready,
   input  dxtd_pkg::dxtd_entry_type push_entry,
   input  logic                     pop,
   output logic                     head_valid,
   output dxtd_pkg::dxtd_entry_type head_entry
);
   import dxtd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   dxtd_entry_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic push;

   assign push_ready = count_ff != CNT_FULL;
   assign head_valid = count_ff != '0;
   assign push = push_valid && push_ready;
   assign head_entry = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_pop_needs_data: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("queue popped while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue count beyond depth");

endmodule

// ===== hw/rtl/dxtd_back.sv =====
module dxtd_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     head_valid,
   input  dxtd_pkg::dxtd_entry_type head_entry,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output dxtd_pkg::dxtd_rsp_type   rsp_data
);
   import dxtd_pkg::*;

   logic [PIX_CNT_W-1:0] pix_cnt_ff, pix_cnt_in;
   logic rsp_valid_ff, rsp_valid_in;
   dxtd_rsp_type rsp_data_ff, rsp_data_in;
   logic load, emit;
   logic [1:0] sel;
   logic [3:0] nib;

   assign load = !rsp_valid_ff || rsp_ready;
   assign emit = load && head_valid;
   assign pop = emit && (pix_cnt_ff == LAST_PIX);

   assign sel = head_entry.indices[{pix_cnt_ff, 1'b0} +: 2];
   assign nib = head_entry.alpha[{pix_cnt_ff, 2'b00} +: 4];

   always_comb begin
      rsp_data_in.pixel = head_entry.palette[sel];
      if (head_entry.explicit_alpha) begin
         rsp_data_in.pixel[31:24] = {nib, nib};
      end
      rsp_data_in.column = pix_cnt_ff[1:0];
      rsp_data_in.row = pix_cnt_ff[3:2];
      rsp_data_in.last = pix_cnt_ff == LAST_PIX;
      pix_cnt_in = emit ? pix_cnt_ff + 1'b1 : pix_cnt_ff;
      rsp_valid_in = emit ? 1'b1 : (load ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pix_cnt_ff <= pix_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   a_last_at_corner: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.last |-> rsp_data_ff.column == 2'd3 &&
                                          rsp_data_ff.row == 2'd3)
      else $error("last flag away from the final pixel");

   a_pop_restarts: assert property (@(posedge clock) disable iff (reset)
      pop |=> pix_cnt_ff == '0)
      else $error("pixel counter not restarted after block");

endmodule

// ===== hw/rtl/dxt_texture_block_decoder_top.sv =====
// channel  direction  handshake              payload
// req      in         req_valid/req_ready    req_data  (color_block, alpha_block)
// rsp      out        rsp_valid/rsp_ready    rsp_data  (pixel, column, row, last)
// csr      in         csr_valid/csr_ready    csr_data  (block_format)
//
// each block gives 16 pixels, one per cycle from the pixel sequencer unless rsp
// backpressure holds it; each pixel is registered onto rsp from the queue head
// the palette is built on accept and parked in a small queue, so blocks are
// taken while the previous one is still being emitted
// rsp backpressure stalls only the sequencer; req stalls once the queue fills
// synchronous reset empties the queue, clears the output and sets DXT1
module dxt_texture_block_decoder_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  dxtd_pkg::dxtd_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output dxtd_pkg::dxtd_rsp_type rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_data
);
   import dxtd_pkg::*;

   logic block_format_ff, block_format_in;
   logic push_valid, push_ready, head_valid, pop;
   dxtd_entry_type push_entry, head_entry;

   assign csr_ready = 1'b1;
   assign block_format_in = (csr_valid && csr_ready) ? csr_data : block_format_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_format_ff <= FMT_DXT1;
      end else begin
         block_format_ff <= block_format_in;
      end
   end

   dxtd_front u_front (
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .block_format (block_format_ff),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_entry   (push_entry)
   );

   dxtd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   dxtd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule
